>>> sv/qrgs_pkg.sv
// ----------------------------------------------------------------------------
// qrgs_pkg
// Shared widths, limits and helpers of the Gram-Schmidt QR block.
// ----------------------------------------------------------------------------
package qrgs_pkg;

	localparam int VAL_W  = 32;
	localparam int PROD_W = 2 * VAL_W;
	localparam int DIVD_W = VAL_W + 16;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [VAL_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

	function automatic val_t sat_val(input prod_t v);
		if (v > PROD_W'(VAL_MAX))
			return VAL_MAX;
		if (v < PROD_W'(VAL_MIN))
			return VAL_MIN;
		return VAL_W'(v);
	endfunction

endpackage

>>> sv/qrgs_if.sv
// ----------------------------------------------------------------------------
// qrgs_if
// Valid/ready channels for matrix elements in and Q/R elements out.
// ----------------------------------------------------------------------------
interface qrgs_in_if import qrgs_pkg::*; ();
	logic valid;
	logic ready;
	val_t elem_value;

	modport source(output valid, output elem_value, input ready);
	modport sink(input valid, input elem_value, output ready);
endinterface

interface qrgs_out_if import qrgs_pkg::*; ();
	logic       valid;
	logic       ready;
	val_t       out_value;
	logic       out_matrix;
	logic [2:0] out_row;
	logic [1:0] out_col;
	logic       zero_norm;
	logic       last;

	modport source(output valid, output out_value, output out_matrix, output out_row,
		output out_col, output zero_norm, output last, input ready);
	modport sink(input valid, input out_value, input out_matrix, input out_row,
		input out_col, input zero_norm, input last, output ready);
endinterface

>>> sv/qr_decomposition_gram_schmidt.sv
// ----------------------------------------------------------------------------
// qr_decomposition_gram_schmidt
// QR decomposition of a small Q16.16 matrix by classical Gram-Schmidt.
// ----------------------------------------------------------------------------
// The block takes the elements of A in row-major order, one transfer per cycle,
// into a single-port-write memory. The transfer of the last element starts the
// decomposition, during which no input is taken. It walks the stored columns
// through one shared multiplier, a bit-serial square root and a bit-serial
// divider: per column it copies the column, forms the dot product with and the
// update against each earlier column, takes the norm and divides by the norm.
// Then it sends the m*n elements of Q and the n*n elements of R, one at a time,
// each held until the sink takes it. Writing a register restarts loading.
module qr_decomposition_gram_schmidt import qrgs_pkg::*; #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	qrgs_in_if.sink     in_ch,
	qrgs_out_if.source  out_ch
);

	localparam int A_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int R_DEPTH = MAX_COLS * MAX_COLS;
	localparam int AW      = $clog2(A_DEPTH);
	localparam int RAW     = (R_DEPTH > 1) ? $clog2(R_DEPTH) : 1;
	localparam int RIW     = $clog2(MAX_ROWS);
	localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW1     = $clog2(MAX_ROWS + 1);
	localparam int CW1     = $clog2(MAX_COLS + 1);
	localparam int ACC_W   = VAL_W + $clog2(MAX_ROWS) + 1;

	localparam logic [3:0] S_LOAD = 4'd0;
	localparam logic [3:0] S_COPY = 4'd1;
	localparam logic [3:0] S_DOT  = 4'd2;
	localparam logic [3:0] S_DOTW = 4'd3;
	localparam logic [3:0] S_SUB  = 4'd4;
	localparam logic [3:0] S_NSQ  = 4'd5;
	localparam logic [3:0] S_SQRT = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_EMIT = 4'd8;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	function automatic logic [AW-1:0] q_addr(input logic [RIW-1:0] r, input logic [CW-1:0] c);
		return AW'(int'(r) * MAX_COLS + int'(c));
	endfunction

	function automatic logic [RAW-1:0] r_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
		return RAW'(int'(r) * MAX_COLS + int'(c));
	endfunction

	// Configuration
	logic [3:0]     rows_q;
	logic [2:0]     cols_q;
	logic           cfg_we;
	logic [RW1-1:0] m_eff;
	logic [CW1-1:0] n_eff;
	logic [RIW-1:0] m_last;
	logic [CW-1:0]  n_last;

	assign cfg_we = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_COLS) ? {29'd0, cols_q} : {28'd0, rows_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 4'd8;
			cols_q <= 3'd4;
		end else if (cfg_we) begin
			unique case (paddr[2])
				REG_ROWS: rows_q <= pwdata[3:0];
				REG_COLS: cols_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (rows_q == 4'd0)
			m_eff = RW1'(1);
		else if (int'(rows_q) > MAX_ROWS)
			m_eff = RW1'(MAX_ROWS);
		else
			m_eff = RW1'(rows_q);
		if (cols_q == 3'd0)
			n_eff = CW1'(1);
		else if (int'(cols_q) > MAX_COLS)
			n_eff = CW1'(MAX_COLS);
		else
			n_eff = CW1'(cols_q);
	end

	assign m_last = RIW'(m_eff - RW1'(1));
	assign n_last = CW'(n_eff - CW1'(1));

	// Sequencer registers
	logic [3:0]       st_q;
	logic [1:0]       ph_q;
	logic [RIW-1:0]   k_q;
	logic [CW-1:0]    i_q;
	logic [CW-1:0]    j_q;
	logic [RIW-1:0]   ld_row_q;
	logic [CW-1:0]    ld_col_q;
	logic [RIW-1:0]   er_q;
	logic [CW-1:0]    ec_q;
	logic             em_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [PROD_W-1:0] ss_q;
	logic [VAL_W-1:0] nrm_q;
	val_t             rij_q;
	val_t             hold_q;
	val_t             fx_q;
	logic             fault_q;
	logic             ov_valid_q;
	val_t             ov_value_q;
	logic             ov_matrix_q;
	logic [2:0]       ov_row_q;
	logic [1:0]       ov_col_q;
	logic             ov_last_q;

	logic in_fire;
	logic out_fire;
	logic last_k;

	assign in_ch.ready = (st_q == S_LOAD);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_fire    = ov_valid_q && out_ch.ready;
	assign last_k      = (k_q == m_last);

	// Memories
	val_t a_mem [A_DEPTH];
	val_t q_mem [A_DEPTH];
	val_t r_mem [R_DEPTH];

	logic [AW-1:0]  a_ra;
	logic [AW-1:0]  q_ra0;
	logic [AW-1:0]  q_ra1;
	logic [RAW-1:0] r_ra;
	val_t           a_rd_s1;
	val_t           q_rd0_s1;
	val_t           q_rd1_s1;
	val_t           r_rd_s1;
	logic           q_we;
	logic [AW-1:0]  q_wa;
	val_t           q_wd;
	logic           r_we;
	logic [RAW-1:0] r_wa;
	val_t           r_wd;

	always_ff @(posedge clk) begin
		if (in_fire)
			a_mem[q_addr(ld_row_q, ld_col_q)] <= in_ch.elem_value;
	end

	always_ff @(posedge clk) begin
		if (q_we)
			q_mem[q_wa] <= q_wd;
	end

	always_ff @(posedge clk) begin
		if (r_we)
			r_mem[r_wa] <= r_wd;
	end

	always_ff @(posedge clk) begin
		a_rd_s1  <= a_mem[a_ra];
		q_rd0_s1 <= q_mem[q_ra0];
		q_rd1_s1 <= q_mem[q_ra1];
		r_rd_s1  <= r_mem[r_ra];
	end

	assign a_ra  = q_addr(k_q, i_q);
	assign q_ra1 = q_addr(k_q, i_q);
	assign q_ra0 = (st_q == S_EMIT) ? q_addr(er_q, ec_q) : q_addr(k_q, j_q);
	assign r_ra  = r_addr(CW'(er_q), ec_q);

	// Arithmetic units
	val_t     mul_a;
	val_t     mul_b;
	prod_t    mul_p;
	val_t     fx_rnd;
	logic     sqrt_start;
	logic     sqrt_done;
	logic [VAL_W-1:0] sqrt_root;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic [VAL_W-1:0] hold_mag;
	val_t     div_res;
	logic [PROD_W:0] ss_sum;

	always_comb begin
		unique case (st_q)
			S_SUB: begin
				mul_a = rij_q;
				mul_b = q_rd0_s1;
			end
			S_NSQ: begin
				mul_a = q_rd1_s1;
				mul_b = q_rd1_s1;
			end
			default: begin
				mul_a = q_rd0_s1;
				mul_b = a_rd_s1;
			end
		endcase
	end

	qrgs_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// Round half up to Q16.16, then saturate.
	assign fx_rnd = sat_val((mul_p + PROD_W'(32768)) >>> 16);

	assign sqrt_start = (st_q == S_SQRT) && (ph_q == 2'd0);

	qrgs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (ss_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	assign hold_mag         = q_rd1_s1[VAL_W-1] ? VAL_W'(-q_rd1_s1) : VAL_W'(q_rd1_s1);
	assign div_req.start    = (st_q == S_DIV) && (ph_q == 2'd1) && (nrm_q != '0);
	assign div_req.dividend = {hold_mag, 16'd0};
	assign div_req.divisor  = nrm_q;

	qrgs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		if (nrm_q == '0)
			div_res = '0;
		else if (!hold_q[VAL_W-1])
			div_res = (div_rsp.quotient > DIVD_W'(VAL_MAX)) ? VAL_MAX
				: VAL_W'(div_rsp.quotient);
		else if (div_rsp.quotient > DIVD_W'({1'b0, VAL_MIN}))
			div_res = VAL_MIN;
		else
			div_res = -VAL_W'(div_rsp.quotient);
	end

	assign ss_sum = (PROD_W + 1)'(ss_q) + (PROD_W + 1)'(unsigned'(mul_p));

	// Memory write ports
	always_comb begin
		q_we = 1'b0;
		q_wa = q_addr(k_q, i_q);
		q_wd = a_rd_s1;
		r_we = 1'b0;
		r_wa = r_addr(j_q, i_q);
		r_wd = sat_val(PROD_W'(acc_q));
		case (st_q)
			S_COPY: q_we = (ph_q == 2'd1);
			S_SUB: begin
				q_we = (ph_q == 2'd3);
				q_wd = sat_val(PROD_W'(hold_q) - PROD_W'(fx_q));
			end
			S_DIV: begin
				q_we = (ph_q == 2'd2) && ((nrm_q == '0) || div_rsp.done);
				q_wd = div_res;
			end
			S_DOTW: r_we = 1'b1;
			S_SQRT: begin
				r_we = sqrt_done;
				r_wa = r_addr(i_q, i_q);
				r_wd = (sqrt_root > VAL_W'(VAL_MAX)) ? VAL_MAX : val_t'(sqrt_root);
			end
			default: ;
		endcase
	end

	// Loading counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_row_q <= '0;
			ld_col_q <= '0;
		end else if (cfg_we) begin
			ld_row_q <= '0;
			ld_col_q <= '0;
		end else if (in_fire) begin
			if (ld_col_q == n_last) begin
				ld_col_q <= '0;
				ld_row_q <= (ld_row_q == m_last) ? '0 : ld_row_q + RIW'(1);
			end else begin
				ld_col_q <= ld_col_q + CW'(1);
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_LOAD;
			ph_q       <= 2'd0;
			k_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			er_q       <= '0;
			ec_q       <= '0;
			em_q       <= 1'b0;
			fault_q    <= 1'b0;
			ov_valid_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_LOAD: begin
					if (in_fire && ld_row_q == m_last && ld_col_q == n_last) begin
						st_q    <= S_COPY;
						ph_q    <= 2'd0;
						k_q     <= '0;
						i_q     <= '0;
						fault_q <= 1'b0;
					end
				end
				S_COPY: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						ph_q <= 2'd0;
						if (last_k) begin
							k_q  <= '0;
							j_q  <= '0;
							st_q <= (i_q == '0) ? S_NSQ : S_DOT;
						end else begin
							k_q <= k_q + RIW'(1);
						end
					end
				end
				S_DOT: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						if (last_k) begin
							k_q  <= '0;
							st_q <= S_DOTW;
						end else begin
							k_q <= k_q + RIW'(1);
						end
					end
				end
				S_DOTW: begin
					st_q <= S_SUB;
					ph_q <= 2'd0;
				end
				S_SUB: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						if (last_k) begin
							k_q <= '0;
							if (CW'(j_q + CW'(1)) == i_q) begin
								st_q <= S_NSQ;
							end else begin
								j_q  <= j_q + CW'(1);
								st_q <= S_DOT;
							end
						end else begin
							k_q <= k_q + RIW'(1);
						end
					end
				end
				S_NSQ: begin
					if (ph_q == 2'd2) begin
						ph_q <= 2'd0;
						if (last_k) begin
							k_q  <= '0;
							st_q <= S_SQRT;
						end else begin
							k_q <= k_q + RIW'(1);
						end
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				S_SQRT: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else if (sqrt_done) begin
						if (r_wd == '0)
							fault_q <= 1'b1;
						ph_q <= 2'd0;
						st_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (ph_q != 2'd2) begin
						ph_q <= ph_q + 2'd1;
					end else if (q_we) begin
						ph_q <= 2'd0;
						if (last_k) begin
							k_q <= '0;
							if (i_q == n_last) begin
								st_q <= S_EMIT;
								er_q <= '0;
								ec_q <= '0;
								em_q <= 1'b0;
							end else begin
								i_q  <= i_q + CW'(1);
								st_q <= S_COPY;
							end
						end else begin
							k_q <= k_q + RIW'(1);
						end
					end
				end
				S_EMIT: begin
					if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else if (ph_q == 2'd1) begin
						ov_valid_q <= 1'b1;
						ph_q       <= 2'd2;
					end else if (out_fire) begin
						ov_valid_q <= 1'b0;
						ph_q       <= 2'd0;
						if (ec_q == n_last) begin
							ec_q <= '0;
							if (em_q && int'(er_q) == int'(n_last)) begin
								st_q <= S_LOAD;
							end else if (!em_q && er_q == m_last) begin
								em_q <= 1'b1;
								er_q <= '0;
							end else begin
								er_q <= er_q + RIW'(1);
							end
						end else begin
							ec_q <= ec_q + CW'(1);
						end
					end
				end
				default: st_q <= S_LOAD;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		fx_q <= fx_rnd;
		if (st_q == S_COPY && ph_q == 2'd1 && i_q != '0)
			acc_q <= '0;
		if (st_q == S_SUB && ph_q == 2'd3 && last_k)
			acc_q <= '0;
		if (st_q == S_DOT && ph_q == 2'd3)
			acc_q <= acc_q + ACC_W'(fx_q);
		if (st_q == S_DOTW)
			rij_q <= r_wd;
		if ((st_q == S_SUB || st_q == S_DIV) && ph_q == 2'd1)
			hold_q <= q_rd1_s1;
		if (st_q == S_COPY)
			ss_q <= '0;
		if (st_q == S_NSQ && ph_q == 2'd2)
			ss_q <= ss_sum[PROD_W] ? '1 : ss_sum[PROD_W-1:0];
		if (st_q == S_SQRT && sqrt_done)
			nrm_q <= unsigned'(r_wd);
		if (st_q == S_EMIT && ph_q == 2'd1) begin
			ov_matrix_q <= em_q;
			ov_row_q    <= 3'(er_q);
			ov_col_q    <= 2'(ec_q);
			ov_last_q   <= em_q && int'(er_q) == int'(n_last) && ec_q == n_last;
			if (!em_q)
				ov_value_q <= q_rd0_s1;
			else if (int'(er_q) > int'(ec_q))
				ov_value_q <= '0;
			else
				ov_value_q <= r_rd_s1;
		end
	end

	assign out_ch.valid      = ov_valid_q;
	assign out_ch.out_value  = ov_value_q;
	assign out_ch.out_matrix = ov_matrix_q;
	assign out_ch.out_row    = ov_row_q;
	assign out_ch.out_col    = ov_col_q;
	assign out_ch.zero_norm  = fault_q;
	assign out_ch.last       = ov_last_q;

`ifndef NO_ASSERTIONS
	a_out_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		ov_valid_q |-> st_q == S_EMIT)
		else $error("result shown outside the emit phase");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && ov_valid_q))
		else $error("input taken while a result is pending");

	a_fault_from_norm: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fault_q) |-> $past(st_q) == S_SQRT)
		else $error("zero-norm flag set outside the norm step");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && ov_last_q) |=> st_q == S_LOAD)
		else $error("final result did not return the block to loading");
`endif

endmodule

>>> sv/qrgs_mul.sv
// ----------------------------------------------------------------------------
// qrgs_mul
// Registered signed multiplier shared by dot products, updates and squares.
// ----------------------------------------------------------------------------
module qrgs_mul import qrgs_pkg::*; (
	input  logic  clk,
	input  val_t  a,
	input  val_t  b,
	output prod_t p
);

	prod_t p_q;

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign p = p_q;

endmodule

>>> sv/qrgs_sqrt.sv
// ----------------------------------------------------------------------------
// qrgs_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module qrgs_sqrt import qrgs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] radicand,
	output logic              done,
	output logic [VAL_W-1:0]  root
);

	logic [PROD_W-1:0] s_q;
	logic [PROD_W-1:0] res_q;
	logic [PROD_W-1:0] bit_q;
	logic              busy_q;
	logic              done_q;
	logic [PROD_W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			s_q   <= radicand;
			res_q <= '0;
			bit_q <= PROD_W'(1) << (PROD_W - 2);
		end else if (busy_q) begin
			if (s_q >= trial) begin
				s_q   <= s_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[VAL_W-1:0];

endmodule

>>> sv/qrgs_div.sv
// ----------------------------------------------------------------------------
// qrgs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qrgs_div import qrgs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIVD_W);

	logic [VAL_W-1:0]  rem_q;
	logic [DIVD_W-1:0] dq_q;
	logic [VAL_W-1:0]  dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [VAL_W:0]    trial;

	assign trial = {rem_q, dq_q[DIVD_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dq_q  <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= VAL_W'(trial - {1'b0, dvs_q});
				dq_q  <= {dq_q[DIVD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[VAL_W-1:0];
				dq_q  <= {dq_q[DIVD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dq_q;

endmodule
